FILE: rtl/psh_pkg.sv
// Shared types, constants and the byte-to-value map of the polynomial string hash.
`timescale 1ns / 1ps

package psh_pkg;

  localparam int unsigned ModW   = 31;                 // table size, hash and power width
  localparam int unsigned ValW   = 5;                  // mapped byte value, 1..27
  localparam int unsigned ProdW  = ModW + ValW;        // value * power, also power * 31
  localparam int unsigned SumW   = ProdW + 1;          // hash + value * power
  localparam int unsigned CntW   = $clog2(SumW + 1);   // remainder step counter
  localparam int unsigned TdataW = ((ModW + 7) / 8) * 8;

  localparam logic [ModW-1:0] TableSizeReset = ModW'(1024);
  localparam logic [ValW-1:0] OtherValue     = ValW'(27);
  localparam logic [7:0]      LowerA         = 8'h61;  // 'a'
  localparam logic [7:0]      UpperA         = 8'h41;  // 'A'

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_POWER,
    ST_EMIT
  } psh_state_e;

  // Letters map to 1..26 in either case, every other byte to 27.
  function automatic logic [ValW-1:0] psh_char_value(input logic [7:0] ch);
    logic [7:0] off;
    off = 8'h00;
    if (ch inside {[8'h61:8'h7a]}) begin
      off = ch - LowerA + 8'd1;
    end else if (ch inside {[8'h41:8'h5a]}) begin
      off = ch - UpperA + 8'd1;
    end else begin
      off = {3'b000, OtherValue};
    end
    return off[ValW-1:0];
  endfunction

endpackage

FILE: rtl/psh_rem_unit.sv
// Shared radix-2 restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module psh_rem_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [psh_pkg::SumW-1:0]      dividend_i,
  input  logic [psh_pkg::ModW-1:0]      modulus_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [psh_pkg::ModW-1:0]      rem_o
);

  logic [psh_pkg::SumW-1:0] div_q, div_d;
  logic [psh_pkg::ModW-1:0] rem_q, rem_d;
  logic [psh_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;

  logic [psh_pkg::ModW:0]   trial;
  logic [psh_pkg::ModW:0]   diff;
  logic                     fits;

  always_comb begin
    trial = {rem_q, div_q[psh_pkg::SumW-1]};
    diff  = trial - {1'b0, modulus_i};
    fits  = trial >= {1'b0, modulus_i};

    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (start_i) begin
      div_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = psh_pkg::CntW'(psh_pkg::SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // trial stays below twice the modulus, so one subtract restores it
      rem_d = fits ? diff[psh_pkg::ModW-1:0] : trial[psh_pkg::ModW-1:0];
      div_d = {div_q[psh_pkg::SumW-2:0], 1'b0};
      cnt_d = cnt_q - psh_pkg::CntW'(1);
      if (cnt_q == psh_pkg::CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/polynomial_string_hash.sv
// Top level of the base-31 polynomial string hash with configurable table size.
`timescale 1ns / 1ps

// Hashes a string fed one byte per beat (tlast on the final byte, tuser set for an
// empty string) into a bucket index below table_size; a zero table size acts as one.
// Each byte runs two reductions through one shared bit-serial remainder unit, 37 steps
// apiece, and the input is held off until both are done; the byte that ends a string
// and an empty-string beat also pass through the emit state before the next byte.
// The finished hash sits in an output register, so the next string may start while
// the result waits to be taken; a second finished string waits until the first has
// been taken. Write table_size only while idle.
module polynomial_string_hash (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: table_size
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [psh_pkg::ModW-1:0]    cfg_data_i,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] character
  input  logic                        s_axis_tlast,
  input  logic                        s_axis_tuser,   // [0] empty_string
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [psh_pkg::TdataW-1:0]  m_axis_tdata    // [30:0] hash, [31] zero
);

  psh_pkg::psh_state_e state_q, state_d;

  logic [psh_pkg::ModW-1:0]  table_size_q;
  logic [psh_pkg::ModW-1:0]  m_eff;
  logic [psh_pkg::ModW-1:0]  hash_q, hash_d;
  logic [psh_pkg::ModW-1:0]  power_q, power_d;
  logic                      last_q, last_d;
  logic [psh_pkg::ModW-1:0]  out_hash_q, out_hash_d;
  logic                      out_valid_q, out_valid_d;

  logic                      in_beat;
  logic [psh_pkg::ValW-1:0]  byte_val;
  logic [psh_pkg::ProdW-1:0] term;
  logic [psh_pkg::ProdW-1:0] power_x31;
  logic [psh_pkg::SumW-1:0]  hash_sum;

  logic                      rem_start;
  logic [psh_pkg::SumW-1:0]  rem_dividend;
  logic                      rem_busy;
  logic                      rem_done;
  logic [psh_pkg::ModW-1:0]  rem_value;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= psh_pkg::TableSizeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      table_size_q <= cfg_data_i;
    end
  end

  assign m_eff = (table_size_q == '0) ? psh_pkg::ModW'(1) : table_size_q;

  assign s_axis_tready = (state_q == psh_pkg::ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  assign byte_val  = psh_pkg::psh_char_value(s_axis_tdata);
  assign term      = psh_pkg::ProdW'(byte_val) * psh_pkg::ProdW'(power_q);
  assign hash_sum  = {1'b0, term} + psh_pkg::SumW'(hash_q);
  assign power_x31 = {power_q, 5'b00000} - psh_pkg::ProdW'(power_q);

  always_comb begin
    state_d      = state_q;
    hash_d       = hash_q;
    power_d      = power_q;
    last_d       = last_q;
    out_hash_d   = out_hash_q;
    out_valid_d  = out_valid_q;
    rem_start    = 1'b0;
    rem_dividend = hash_sum;

    // drop the result once the downstream side takes it
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      psh_pkg::ST_IDLE: begin
        if (in_beat) begin
          last_d = s_axis_tlast;
          if (s_axis_tuser) begin
            // empty string discards any partial string and reports zero
            hash_d  = '0;
            power_d = psh_pkg::ModW'(1);
            state_d = psh_pkg::ST_EMIT;
          end else begin
            rem_start = 1'b1;
            state_d   = psh_pkg::ST_HASH;
          end
        end
      end
      psh_pkg::ST_HASH: begin
        rem_dividend = psh_pkg::SumW'(power_x31);
        if (rem_done) begin
          hash_d    = rem_value;
          rem_start = 1'b1;
          state_d   = psh_pkg::ST_POWER;
        end
      end
      psh_pkg::ST_POWER: begin
        if (rem_done) begin
          power_d = rem_value;
          state_d = last_q ? psh_pkg::ST_EMIT : psh_pkg::ST_IDLE;
        end
      end
      psh_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_hash_d  = hash_q;
          out_valid_d = 1'b1;
          hash_d      = '0;
          power_d     = psh_pkg::ModW'(1);
          state_d     = psh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = psh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psh_pkg::ST_IDLE;
      hash_q      <= '0;
      power_q     <= psh_pkg::ModW'(1);
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      power_q     <= power_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hash_q <= out_hash_d;
  end

  psh_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .modulus_i  (m_eff),
    .busy_o     (rem_busy),
    .done_o     (rem_done),
    .rem_o      (rem_value)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = psh_pkg::TdataW'(out_hash_q);

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_start |-> !rem_busy)
    else $error("remainder unit restarted while busy");

  a_done_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (state_q == psh_pkg::ST_HASH || state_q == psh_pkg::ST_POWER))
    else $error("remainder result arrived outside a reduction step");

  a_byte_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && !s_axis_tuser) |=> (state_q == psh_pkg::ST_HASH && rem_busy))
    else $error("accepted byte did not start the hash reduction");

  a_hash_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == psh_pkg::ST_POWER) |-> (hash_q < m_eff))
    else $error("running hash not below table size");

endmodule
